[src/ssp_pkg.sv]
// Shared types and constants for the two-speed shuttle positioner.
// Used by every module in src; depends on nothing.
package ssp_pkg;

	// Field widths
	localparam int PosW    = 12;
	localparam int SelW    = 5;
	localparam int ThrW    = 12;
	localparam int CompW   = 8;
	localparam int TickW   = 16;
	localparam int PulseW  = 8;
	localparam int StatW   = 3;
	localparam int CfgIdxW = 2;
	localparam int CfgDatW = 16;

	// Selection stepping and scaling
	localparam logic [SelW-1:0] DistStep   = SelW'(5);
	localparam logic [SelW-1:0] DistWrap   = SelW'(30);
	localparam logic [SelW-1:0] SelReset   = SelW'(5);
	localparam logic [6:0]      CmPerUnit  = 7'd100;
	localparam logic [PosW-1:0] PosMax     = {PosW{1'b1}};
	localparam logic [TickW-1:0] TickMax   = {TickW{1'b1}};

	// Register reset values
	localparam logic [ThrW-1:0]   ThrReset     = ThrW'(150);
	localparam logic [CompW-1:0]  CompReset    = CompW'(0);
	localparam logic [TickW-1:0]  TimeoutReset = TickW'(15000);
	localparam logic [PulseW-1:0] PulseReset   = PulseW'(1);

	// Input item kinds
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_PULSE = 2'd1,
		REQ_DIST  = 2'd2,
		REQ_START = 2'd3
	} req_t;

	// Result status codes
	typedef enum logic [StatW-1:0] {
		ST_NONE   = 3'd0,
		ST_REJECT = 3'd1,
		ST_STALL  = 3'd2,
		ST_DONE   = 3'd3,
		ST_HOMED  = 3'd4
	} status_t;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SLOW_THR = 2'd0,
		CFG_STOP_CMP = 2'd1,
		CFG_TIMEOUT  = 2'd2,
		CFG_CM_PULSE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ThrW-1:0]   slow_threshold;
		logic [CompW-1:0]  stop_comp;
		logic [TickW-1:0]  timeout_ticks;
		logic [PulseW-1:0] cm_per_pulse;
	} cfg_t;

	typedef struct packed {
		logic            motor_on;
		logic            drive_forward;
		logic            slow_speed;
		logic [PosW-1:0] position_cm;
		logic [SelW-1:0] selected_m;
		status_t         status;
	} result_t;

endpackage

[src/ssp_cfg.sv]
// Configuration register file for the shuttle positioner.
// Depends on ssp_pkg.
module ssp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [ssp_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [ssp_pkg::CfgDatW-1:0]     cfg_data,
	output ssp_pkg::cfg_t                   cfg
);

	ssp_pkg::cfg_t cfg_q;

	// Register writes; every beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_threshold <= ssp_pkg::ThrReset;
			cfg_q.stop_comp      <= ssp_pkg::CompReset;
			cfg_q.timeout_ticks  <= ssp_pkg::TimeoutReset;
			cfg_q.cm_per_pulse   <= ssp_pkg::PulseReset;
		end else if (cfg_valid) begin
			unique case (ssp_pkg::cfg_idx_t'(cfg_index))
				ssp_pkg::CFG_SLOW_THR: cfg_q.slow_threshold <= cfg_data[ssp_pkg::ThrW-1:0];
				ssp_pkg::CFG_STOP_CMP: cfg_q.stop_comp      <= cfg_data[ssp_pkg::CompW-1:0];
				ssp_pkg::CFG_TIMEOUT:  cfg_q.timeout_ticks  <= cfg_data[ssp_pkg::TickW-1:0];
				ssp_pkg::CFG_CM_PULSE: cfg_q.cm_per_pulse   <= cfg_data[ssp_pkg::PulseW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/ssp_core.sv]
// Run controller: mode, position, selection and timers, updated once per item.
// Depends on ssp_pkg.
module ssp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  ssp_pkg::req_t               req,
	input  logic                        endstop,
	input  ssp_pkg::cfg_t               cfg,
	output ssp_pkg::result_t            result
);

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_HWAIT = 3'd1,
		M_HRUN  = 3'd2,
		M_FWD   = 3'd3,
		M_REV   = 3'd4
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic [ssp_pkg::PosW-1:0]     pos_q, pos_d;
	logic [ssp_pkg::SelW-1:0]     sel_q, sel_d;
	logic                         fwd_next_q, fwd_next_d;
	logic                         slowing_q, slowing_d;
	logic [ssp_pkg::TickW-1:0]    elapsed_q, elapsed_d;
	ssp_pkg::status_t             status_d;

	logic [11:0]                  target_raw;
	logic [ssp_pkg::PosW-1:0]     target;
	logic [ssp_pkg::PosW:0]       margin;
	logic [ssp_pkg::SelW:0]       sel_sum;
	logic [ssp_pkg::SelW-1:0]     sel_wrap;
	logic                         stall_now;
	logic [ssp_pkg::TickW-1:0]    elapsed_inc;
	logic [ssp_pkg::PosW:0]       pos_add;
	logic [ssp_pkg::PosW-1:0]     pos_fwd, pos_rev;
	logic                         motor;

	// Slow point: forward when within margin of target, reverse when within margin of home
	function automatic logic slow_hit(input logic fwd, input logic [ssp_pkg::PosW-1:0] pos,
			input logic [ssp_pkg::PosW:0] mrg, input logic [ssp_pkg::PosW-1:0] tgt);
		logic [ssp_pkg::PosW+1:0] reach;
		reach = {2'b00, pos} + {1'b0, mrg};
		if (fwd)
			slow_hit = reach >= {2'b00, tgt};
		else
			slow_hit = {1'b0, pos} <= mrg;
	endfunction

	// Target distance and shared helpers
	always_comb begin
		target_raw  = 12'(sel_q) * 12'(ssp_pkg::CmPerUnit);
		target      = (target_raw > ssp_pkg::PosMax) ? ssp_pkg::PosMax : target_raw;
		margin      = {1'b0, cfg.slow_threshold} + ssp_pkg::PosW'(cfg.stop_comp);
		sel_sum     = {1'b0, sel_q} + {1'b0, ssp_pkg::DistStep};
		sel_wrap    = (sel_sum >= {1'b0, ssp_pkg::DistWrap}) ?
		              ssp_pkg::SelW'(sel_sum - {1'b0, ssp_pkg::DistWrap}) :
		              sel_sum[ssp_pkg::SelW-1:0];
		stall_now   = elapsed_q >= cfg.timeout_ticks;
		elapsed_inc = (elapsed_q == ssp_pkg::TickMax) ? elapsed_q : elapsed_q + 1'b1;
		pos_add     = {1'b0, pos_q} + ssp_pkg::PosW'(cfg.cm_per_pulse);
		pos_fwd     = pos_add[ssp_pkg::PosW] ? ssp_pkg::PosMax : pos_add[ssp_pkg::PosW-1:0];
		pos_rev     = (pos_q > ssp_pkg::PosW'(cfg.cm_per_pulse)) ?
		              pos_q - ssp_pkg::PosW'(cfg.cm_per_pulse) : '0;
	end

	// Next state for one item
	always_comb begin
		logic run_fwd;
		logic stall;
		logic done;
		logic [ssp_pkg::PosW-1:0] pos_n;
		mode_d     = mode_q;
		pos_d      = pos_q;
		sel_d      = sel_q;
		fwd_next_d = fwd_next_q;
		slowing_d  = slowing_q;
		elapsed_d  = elapsed_q;
		status_d   = ssp_pkg::ST_NONE;
		run_fwd    = (mode_q != M_REV);
		stall      = 1'b0;
		done       = 1'b0;
		pos_n      = pos_q;
		unique case (mode_q)
			M_IDLE: begin
				if (req == ssp_pkg::REQ_DIST && endstop) begin
					sel_d = sel_wrap;
				end else if (req == ssp_pkg::REQ_START) begin
					if (sel_q == '0) begin
						status_d = ssp_pkg::ST_REJECT;
					end else begin
						elapsed_d = '0;
						if (fwd_next_q) begin
							mode_d    = M_FWD;
							pos_d     = '0;
							slowing_d = slow_hit(1'b1, '0, margin, target);
						end else if (target == '0 || endstop) begin
							// reverse start already at home
							mode_d     = M_IDLE;
							pos_d      = target;
							slowing_d  = 1'b0;
							fwd_next_d = ~fwd_next_q;
							status_d   = ssp_pkg::ST_DONE;
						end else begin
							mode_d    = M_REV;
							pos_d     = target;
							slowing_d = slow_hit(1'b0, target, margin, target);
						end
					end
				end
			end
			M_HWAIT: begin
				if (endstop) begin
					mode_d     = M_IDLE;
					pos_d      = '0;
					fwd_next_d = 1'b1;
					slowing_d  = 1'b0;
					status_d   = ssp_pkg::ST_HOMED;
				end else if (req == ssp_pkg::REQ_START) begin
					mode_d    = M_HRUN;
					elapsed_d = '0;
				end
			end
			M_HRUN: begin
				if (endstop) begin
					mode_d     = M_IDLE;
					pos_d      = '0;
					fwd_next_d = 1'b1;
					slowing_d  = 1'b0;
					status_d   = ssp_pkg::ST_HOMED;
				end else if (req == ssp_pkg::REQ_TICK) begin
					if (stall_now) begin
						mode_d    = M_HWAIT;
						slowing_d = 1'b0;
						status_d  = ssp_pkg::ST_STALL;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
			end
			default: begin
				// forward or reverse run; unused codes run forward
				mode_d = run_fwd ? M_FWD : M_REV;
				if (req == ssp_pkg::REQ_PULSE) begin
					pos_n = run_fwd ? pos_fwd : pos_rev;
				end else if (req == ssp_pkg::REQ_TICK) begin
					stall = stall_now;
					if (!stall_now)
						elapsed_d = elapsed_inc;
				end
				pos_d = pos_n;
				done  = run_fwd ? (pos_n >= target) : (pos_n == '0 || endstop);
				if (done) begin
					mode_d     = M_IDLE;
					slowing_d  = 1'b0;
					fwd_next_d = ~fwd_next_q;
					status_d   = ssp_pkg::ST_DONE;
				end else if (stall) begin
					mode_d    = M_HWAIT;
					slowing_d = 1'b0;
					status_d  = ssp_pkg::ST_STALL;
				end else begin
					slowing_d = slowing_q | slow_hit(run_fwd, pos_n, margin, target);
				end
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_HWAIT;
			pos_q      <= '0;
			sel_q      <= ssp_pkg::SelReset;
			fwd_next_q <= 1'b1;
			slowing_q  <= 1'b0;
			elapsed_q  <= '0;
		end else if (step) begin
			mode_q     <= mode_d;
			pos_q      <= pos_d;
			sel_q      <= sel_d;
			fwd_next_q <= fwd_next_d;
			slowing_q  <= slowing_d;
			elapsed_q  <= elapsed_d;
		end
	end

	// Result fields from the updated state
	always_comb begin
		motor                = (mode_d == M_HRUN) || (mode_d == M_FWD) || (mode_d == M_REV);
		result.motor_on      = motor;
		result.drive_forward = (mode_d == M_FWD);
		result.slow_speed    = (mode_d == M_HRUN) || (motor && slowing_d);
		result.position_cm   = pos_d;
		result.selected_m    = sel_d;
		result.status        = status_d;
	end

endmodule

[src/two_speed_shuttle_positioner.sv]
// Top level of the two-speed shuttle positioner: input register, run controller,
// configuration registers and result register. Depends on ssp_pkg, ssp_cfg, ssp_core.

// Each input beat (tick, encoder pulse, distance press or start press, with the
// endstop level) gives exactly one result beat. A beat is registered on entry and
// its result is registered once the result register is empty or being drained; one
// beat is taken every cycle while the result register is empty or being drained, so
// throughput is one item per clock. The configuration port is always ready; write
// registers only while no item is in flight.
module two_speed_shuttle_positioner (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      req_type,
	input  logic                            endstop_active,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            motor_on,
	output logic                            drive_forward,
	output logic                            slow_speed,
	output logic [ssp_pkg::PosW-1:0]        position_cm,
	output logic [ssp_pkg::SelW-1:0]        selected_m,
	output logic [ssp_pkg::StatW-1:0]       status,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ssp_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [ssp_pkg::CfgDatW-1:0]     cfg_data
);

	logic              valid_s1;
	ssp_pkg::req_t     req_s1;
	logic              endstop_s1;
	logic              step;
	logic              out_valid_q;
	ssp_pkg::result_t  result;
	ssp_pkg::result_t  result_q;
	ssp_pkg::cfg_t     cfg;

	// Advance when an item waits and the result register can take it
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1     <= ssp_pkg::req_t'(req_type);
			endstop_s1 <= endstop_active;
		end
	end

	ssp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.req     (req_s1),
		.endstop (endstop_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_on      = result_q.motor_on;
	assign drive_forward = result_q.drive_forward;
	assign slow_speed    = result_q.slow_speed;
	assign position_cm   = result_q.position_cm;
	assign selected_m    = result_q.selected_m;
	assign status        = result_q.status;

endmodule
